// ===== rtl/core/irc_lp_pkg.sv =====
// irc_lp_pkg: shared types, codes and the command name table of the IRC line parser.
// Depends on nothing; the command unit and the top level use it by scoped names.
package irc_lp_pkg;

   // parse phases, one-hot
   typedef enum logic [9:0] {
      PH_START = 10'b00_0000_0001,
      PH_NICK  = 10'b00_0000_0010,
      PH_HOST  = 10'b00_0000_0100,
      PH_CMD   = 10'b00_0000_1000,
      PH_PARAM = 10'b00_0001_0000,
      PH_TEXT  = 10'b00_0010_0000,
      PH_TAG   = 10'b00_0100_0000,
      PH_ARGS  = 10'b00_1000_0000,
      PH_DROP  = 10'b01_0000_0000,
      PH_ERR   = 10'b10_0000_0000
   } phase_type;

   // byte tags
   localparam logic [3:0] KIND_DROP    = 4'd0;
   localparam logic [3:0] KIND_NICK    = 4'd1;
   localparam logic [3:0] KIND_HOST    = 4'd2;
   localparam logic [3:0] KIND_CMD     = 4'd3;
   localparam logic [3:0] KIND_PARAM   = 4'd4;
   localparam logic [3:0] KIND_RESTART = 4'd5;
   localparam logic [3:0] KIND_TEXT    = 4'd6;
   localparam logic [3:0] KIND_TAG     = 4'd7;
   localparam logic [3:0] KIND_ARGS    = 4'd8;

   // command classes
   localparam logic [1:0] CK_UNKNOWN = 2'd0;
   localparam logic [1:0] CK_NAMED   = 2'd1;
   localparam logic [1:0] CK_NUMERIC = 2'd2;

   // line status
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_PREFIX    = 2'd1;
   localparam logic [1:0] ST_TOO_MANY  = 2'd2;

   // characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SOH   = 8'h01;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_Z  = 8'h7a;
   localparam logic [7:0] CASE_GAP = 8'h20;

   localparam logic [9:0] NUM_SAT = 10'd999;

   // name table: left-justified text, zero padded to eight characters
   localparam int NAME_MAX   = 8;
   localparam int NAME_IDX_W = 3;
   localparam int NUM_NAMES  = 35;
   localparam logic [9:0] IDX_NOTICE  = 10'd20;
   localparam logic [9:0] IDX_PRIVMSG = 10'd21;

   localparam logic [63:0] NAME_TEXT [NUM_NAMES] = '{
      {"PASS", 32'd0}, {"NICK", 32'd0}, {"USER", 32'd0}, {"OPER", 32'd0},
      {"QUIT", 32'd0}, {"JOIN", 32'd0}, {"PART", 32'd0}, {"MODE", 32'd0},
      {"TOPIC", 24'd0}, {"NAMES", 24'd0}, {"LIST", 32'd0}, {"KICK", 32'd0},
      {"VERSION", 8'd0}, {"STATS", 24'd0}, {"LINKS", 24'd0}, {"TIME", 32'd0},
      {"CONNECT", 8'd0}, {"TRACE", 24'd0}, {"ADMIN", 24'd0}, {"INFO", 32'd0},
      {"NOTICE", 16'd0}, {"PRIVMSG", 8'd0}, {"INVITE", 16'd0}, {"WHO", 40'd0},
      {"WHOIS", 24'd0}, {"WHOWAS", 16'd0}, {"PING", 32'd0}, {"PONG", 32'd0},
      {"MOTD", 32'd0}, {"LUSERS", 16'd0}, {"ERROR", 24'd0}, {"SQUIT", 24'd0},
      {"SERVLIST"}, {"SQUERY", 16'd0}, {"KILL", 32'd0}
   };

   localparam logic [3:0] NAME_LEN [NUM_NAMES] = '{
      4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd4, 4'd4,
      4'd7, 4'd5, 4'd5, 4'd4, 4'd7, 4'd5, 4'd5, 4'd4, 4'd6, 4'd7, 4'd6, 4'd3,
      4'd5, 4'd6, 4'd4, 4'd4, 4'd4, 4'd6, 4'd5, 4'd5, 4'd8, 4'd6, 4'd4
   };

   // command decode result
   typedef struct packed {
      logic [1:0] kind;
      logic [9:0] value;
   } cmd_stat_type;

   // requests from the phase logic to the command unit
   typedef struct packed {
      logic push;     // command byte
      logic finish;   // latch the decode
      logic clear;    // end of line
   } cmd_ctrl_type;

   // match the stored command against the name table
   function automatic cmd_stat_type name_lookup(
      input logic [NAME_MAX-1:0][7:0] chars,
      input logic [4:0]               len
   );
      cmd_stat_type res;
      logic         hit;
      logic         found;
      res   = '{kind: CK_UNKNOWN, value: 10'd0};
      found = 1'b0;
      for (int i = 0; i < NUM_NAMES; i++) begin
         hit = ({1'b0, NAME_LEN[i]} == len);
         for (int k = 0; k < NAME_MAX; k++) begin
            if ((4'(k) < NAME_LEN[i]) && (chars[k] != NAME_TEXT[i][63 - 8 * k -: 8])) begin
               hit = 1'b0;
            end
         end
         if (hit && !found) begin
            found     = 1'b1;
            res.kind  = CK_NAMED;
            res.value = 10'(i);
         end
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/irc_lp_in_stage.sv =====
// irc_lp_in_stage: input register of the IRC line parser, one request deep.
// Depends on no other file; no package items used.
module irc_lp_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       advance,
   output logic       held_valid,
   output logic [7:0] held_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       take;
   logic       accept;

   // the held byte moves on when the parse stage advances
   assign take      = valid_ff && advance;
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_in_byte;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

endmodule

// ===== rtl/core/irc_lp_cmd_unit.sv =====
// irc_lp_cmd_unit: command accumulator (text, length, numeric value) and name decode.
// Depends on irc_lp_pkg for the name table, codes and control structs.
module irc_lp_cmd_unit #(
   parameter int CMD_LEN = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  irc_lp_pkg::cmd_ctrl_type ctrl,
   input  logic [7:0]              in_byte,
   output logic [7:0]              cmd_byte,
   output irc_lp_pkg::cmd_stat_type fin,
   output irc_lp_pkg::cmd_stat_type cur
);

   localparam int LEN_W = $clog2(CMD_LEN + 2);

   logic [LEN_W-1:0] len_ff, len_in;
   logic [9:0]       nv_ff, nv_in;
   logic             num_ff, num_in;
   logic             dopen_ff, dopen_in;
   irc_lp_pkg::cmd_stat_type stat_ff, stat_in;
   logic [irc_lp_pkg::NAME_MAX-1:0][7:0] chars_ff;

   logic        first;
   logic        is_digit;
   logic        is_lower;
   logic        num_now;
   logic        dopen_now;
   logic [13:0] prod;
   logic        store;
   irc_lp_pkg::cmd_stat_type look;

   assign first    = (len_ff == '0);
   assign is_digit = (in_byte >= irc_lp_pkg::CH_ZERO) && (in_byte <= irc_lp_pkg::CH_NINE);
   assign is_lower = (in_byte >= irc_lp_pkg::CH_LO_A) && (in_byte <= irc_lp_pkg::CH_LO_Z);
   assign num_now   = first ? is_digit : num_ff;
   assign dopen_now = first ? is_digit : dopen_ff;
   assign prod      = 14'(nv_ff) * 14'd10 + 14'(in_byte) - 14'(irc_lp_pkg::CH_ZERO);
   assign store     = (len_ff < LEN_W'(irc_lp_pkg::NAME_MAX));

   // upper-case unless the command opened with a digit
   assign cmd_byte = (!num_now && is_lower) ? (in_byte - irc_lp_pkg::CASE_GAP) : in_byte;

   // decode of what has been collected so far
   assign look = irc_lp_pkg::name_lookup(chars_ff, 5'(len_ff));
   always_comb begin
      fin = '{kind: irc_lp_pkg::CK_UNKNOWN, value: 10'd0};
      if (first) begin
         fin = '{kind: irc_lp_pkg::CK_UNKNOWN, value: 10'd0};
      end else if (num_ff) begin
         fin = '{kind: irc_lp_pkg::CK_NUMERIC, value: nv_ff};
      end else if (len_ff <= LEN_W'(CMD_LEN)) begin
         fin = look;
      end
   end

   // accumulator update
   always_comb begin
      len_in   = len_ff;
      nv_in    = nv_ff;
      num_in   = num_ff;
      dopen_in = dopen_ff;
      stat_in  = stat_ff;
      if (ctrl.clear) begin
         len_in   = '0;
         nv_in    = 10'd0;
         num_in   = 1'b0;
         dopen_in = 1'b0;
         stat_in  = '{kind: irc_lp_pkg::CK_UNKNOWN, value: 10'd0};
      end else if (ctrl.push) begin
         num_in   = num_now;
         dopen_in = dopen_now && is_digit;
         if (dopen_now && is_digit) begin
            nv_in = (prod > 14'(irc_lp_pkg::NUM_SAT)) ? irc_lp_pkg::NUM_SAT : prod[9:0];
         end
         if (len_ff <= LEN_W'(CMD_LEN)) begin
            len_in = len_ff + LEN_W'(1);
         end
      end else if (ctrl.finish) begin
         stat_in = fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         nv_ff    <= 10'd0;
         num_ff   <= 1'b0;
         dopen_ff <= 1'b0;
         stat_ff  <= '{kind: irc_lp_pkg::CK_UNKNOWN, value: 10'd0};
      end else begin
         len_ff   <= len_in;
         nv_ff    <= nv_in;
         num_ff   <= num_in;
         dopen_ff <= dopen_in;
         stat_ff  <= stat_in;
      end
   end

   // command text store, only read at places already written this line
   always_ff @(posedge clock) begin
      if (ctrl.push && !ctrl.clear && store) begin
         chars_ff[len_ff[irc_lp_pkg::NAME_IDX_W-1:0]] <= cmd_byte;
      end
   end

   assign cur = stat_ff;

endmodule

// ===== rtl/core/irc_line_parser.sv =====
// irc_line_parser: tags each byte of an IRC line and reports a summary at its end.
// A byte passes the input register, then the result register; each holds one request.
// Throughput: one byte per cycle while rsp_stall is low.
// Reset (synchronous): clears the parse phase, counters, command unit and both valid flags.
// The command text store is not cleared; it is only read where written in the current line.
// Depends on irc_lp_pkg, irc_lp_in_stage and irc_lp_cmd_unit.
module irc_line_parser #(
   parameter int PARAM_MAX = 16,
   parameter int CTCP_MAX  = 8,
   parameter int TEXT_MAX  = 512,
   parameter int CMD_LEN   = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [3:0] rsp_kind,
   output logic [3:0] rsp_param_index,
   output logic [2:0] rsp_ctcp_index,
   output logic       rsp_line_end,
   output logic [1:0] rsp_command_kind,
   output logic [9:0] rsp_command_value,
   output logic [4:0] rsp_param_count,
   output logic [3:0] rsp_ctcp_count,
   output logic       rsp_has_trailing,
   output logic [1:0] rsp_status
);

   localparam int PC_W = $clog2(PARAM_MAX);
   localparam int CC_W = $clog2(CTCP_MAX + 1);
   localparam int TC_W = $clog2(TEXT_MAX + 1);

   logic       advance;
   logic       in_vld;
   logic [7:0] in_byte;
   logic       step;

   irc_lp_pkg::cmd_ctrl_type ctrl;
   irc_lp_pkg::cmd_stat_type fin;
   irc_lp_pkg::cmd_stat_type cur;
   logic [7:0] cmd_byte;

   irc_lp_pkg::phase_type phase_ff, phase_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic [CC_W-1:0] cc_ff, cc_in;
   logic [TC_W-1:0] tc_ff, tc_in;
   logic [1:0]      err_ff, err_in;
   logic            trail_ff, trail_in;
   logic            cmode_ff, cmode_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic       term;
   logic [7:0] o_byte;
   logic [3:0] o_kind;
   logic [3:0] o_pidx;
   logic [2:0] o_cidx;
   logic       o_end;
   logic [1:0] o_ckind;
   logic [9:0] o_cval;
   logic [4:0] o_pcnt;
   logic [3:0] o_ccnt;
   logic       o_trail;
   logic [1:0] o_status;

   logic [7:0] out_byte_ff;
   logic [3:0] kind_ff;
   logic [3:0] pidx_ff;
   logic [2:0] cidx_ff;
   logic       end_ff;
   logic [1:0] ckind_ff;
   logic [9:0] cval_ff;
   logic [4:0] pcnt_ff;
   logic [3:0] ccnt_ff;
   logic       trail_out_ff;
   logic [1:0] status_ff;

   // the parse stage moves when the result register is free or being emptied
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign step    = in_vld && advance;

   irc_lp_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .advance     (advance),
      .held_valid  (in_vld),
      .held_byte   (in_byte)
   );

   irc_lp_cmd_unit #(
      .CMD_LEN (CMD_LEN)
   ) u_cmd (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .in_byte  (in_byte),
      .cmd_byte (cmd_byte),
      .fin      (fin),
      .cur      (cur)
   );

   assign term = (in_byte == irc_lp_pkg::CH_CR) || (in_byte == irc_lp_pkg::CH_LF) ||
                 (in_byte == irc_lp_pkg::CH_NUL);

   // phase logic: tag the byte and advance the line state
   always_comb begin
      phase_in = phase_ff;
      pc_in    = pc_ff;
      cc_in    = cc_ff;
      tc_in    = tc_ff;
      err_in   = err_ff;
      trail_in = trail_ff;
      cmode_in = cmode_ff;
      ctrl     = '{push: 1'b0, finish: 1'b0, clear: 1'b0};
      o_byte   = in_byte;
      o_kind   = irc_lp_pkg::KIND_DROP;
      o_pidx   = 4'd0;
      o_cidx   = 3'd0;
      o_end    = 1'b0;
      o_ckind  = irc_lp_pkg::CK_UNKNOWN;
      o_cval   = 10'd0;
      o_pcnt   = 5'd0;
      o_ccnt   = 4'd0;
      o_trail  = 1'b0;
      o_status = irc_lp_pkg::ST_OK;
      if (step) begin
         if (term) begin
            // end of line: report the summary, then start afresh
            ctrl.clear = 1'b1;
            o_end      = 1'b1;
            if (phase_ff == irc_lp_pkg::PH_CMD) begin
               o_ckind = fin.kind;
               o_cval  = fin.value;
            end else begin
               o_ckind = cur.kind;
               o_cval  = cur.value;
            end
            if ((phase_ff == irc_lp_pkg::PH_NICK) || (phase_ff == irc_lp_pkg::PH_HOST)) begin
               o_status = irc_lp_pkg::ST_PREFIX;
            end else begin
               o_status = err_ff;
            end
            if ((phase_ff == irc_lp_pkg::PH_TAG) || (phase_ff == irc_lp_pkg::PH_ARGS)) begin
               o_ccnt = 4'(cc_ff + CC_W'(1));
            end else begin
               o_ccnt = 4'(cc_ff);
            end
            o_pcnt   = 5'(pc_ff) + 5'd1;
            o_trail  = trail_ff;
            phase_in = irc_lp_pkg::PH_START;
            pc_in    = '0;
            cc_in    = '0;
            tc_in    = '0;
            err_in   = irc_lp_pkg::ST_OK;
            trail_in = 1'b0;
            cmode_in = 1'b0;
         end else begin
            case (phase_ff)
               irc_lp_pkg::PH_START: begin
                  if (in_byte == irc_lp_pkg::CH_COLON) begin
                     phase_in = irc_lp_pkg::PH_NICK;
                  end else if (in_byte == irc_lp_pkg::CH_SPACE) begin
                     ctrl.finish = 1'b1;
                     phase_in    = irc_lp_pkg::PH_PARAM;
                  end else begin
                     ctrl.push = 1'b1;
                     o_byte    = cmd_byte;
                     o_kind    = irc_lp_pkg::KIND_CMD;
                     phase_in  = irc_lp_pkg::PH_CMD;
                  end
               end
               irc_lp_pkg::PH_NICK: begin
                  if (in_byte == irc_lp_pkg::CH_BANG) begin
                     phase_in = irc_lp_pkg::PH_HOST;
                  end else if (in_byte == irc_lp_pkg::CH_SPACE) begin
                     phase_in = irc_lp_pkg::PH_CMD;
                  end else begin
                     o_kind = irc_lp_pkg::KIND_NICK;
                  end
               end
               irc_lp_pkg::PH_HOST: begin
                  if (in_byte == irc_lp_pkg::CH_SPACE) begin
                     phase_in = irc_lp_pkg::PH_CMD;
                  end else begin
                     o_kind = irc_lp_pkg::KIND_HOST;
                  end
               end
               irc_lp_pkg::PH_CMD: begin
                  if (in_byte == irc_lp_pkg::CH_SPACE) begin
                     ctrl.finish = 1'b1;
                     phase_in    = irc_lp_pkg::PH_PARAM;
                  end else begin
                     ctrl.push = 1'b1;
                     o_byte    = cmd_byte;
                     o_kind    = irc_lp_pkg::KIND_CMD;
                  end
               end
               irc_lp_pkg::PH_PARAM: begin
                  if (in_byte == irc_lp_pkg::CH_COLON) begin
                     o_kind   = irc_lp_pkg::KIND_RESTART;
                     o_pidx   = 4'(pc_ff);
                     trail_in = 1'b1;
                     cmode_in = (cur.kind == irc_lp_pkg::CK_NAMED) &&
                                ((cur.value == irc_lp_pkg::IDX_PRIVMSG) ||
                                 (cur.value == irc_lp_pkg::IDX_NOTICE));
                     phase_in = irc_lp_pkg::PH_TEXT;
                  end else if (in_byte == irc_lp_pkg::CH_SPACE) begin
                     if (pc_ff == PC_W'(PARAM_MAX - 1)) begin
                        err_in   = irc_lp_pkg::ST_TOO_MANY;
                        phase_in = irc_lp_pkg::PH_ERR;
                     end else begin
                        pc_in = pc_ff + PC_W'(1);
                     end
                  end else begin
                     o_kind = irc_lp_pkg::KIND_PARAM;
                     o_pidx = 4'(pc_ff);
                  end
               end
               irc_lp_pkg::PH_TEXT: begin
                  if (cmode_ff && (in_byte == irc_lp_pkg::CH_SOH)) begin
                     if (cc_ff >= CC_W'(CTCP_MAX)) begin
                        phase_in = irc_lp_pkg::PH_DROP;
                     end else begin
                        phase_in = irc_lp_pkg::PH_TAG;
                     end
                  end else begin
                     o_kind = irc_lp_pkg::KIND_TEXT;
                     o_pidx = 4'(pc_ff);
                     if (cmode_ff) begin
                        tc_in = tc_ff + TC_W'(1);
                        if (tc_ff == TC_W'(TEXT_MAX - 1)) begin
                           phase_in = irc_lp_pkg::PH_DROP;
                        end
                     end
                  end
               end
               irc_lp_pkg::PH_TAG: begin
                  if (in_byte == irc_lp_pkg::CH_SOH) begin
                     cc_in    = cc_ff + CC_W'(1);
                     phase_in = irc_lp_pkg::PH_TEXT;
                  end else if (in_byte == irc_lp_pkg::CH_SPACE) begin
                     phase_in = irc_lp_pkg::PH_ARGS;
                  end else begin
                     o_kind = irc_lp_pkg::KIND_TAG;
                     o_pidx = 4'(pc_ff);
                     o_cidx = 3'(cc_ff);
                  end
               end
               irc_lp_pkg::PH_ARGS: begin
                  if (in_byte == irc_lp_pkg::CH_SOH) begin
                     cc_in    = cc_ff + CC_W'(1);
                     phase_in = irc_lp_pkg::PH_TEXT;
                  end else begin
                     o_kind = irc_lp_pkg::KIND_ARGS;
                     o_pidx = 4'(pc_ff);
                     o_cidx = 3'(cc_ff);
                  end
               end
               default: begin
                  // dropped tail of the line
                  o_kind = irc_lp_pkg::KIND_DROP;
               end
            endcase
         end
      end
   end

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= irc_lp_pkg::PH_START;
         pc_ff        <= '0;
         cc_ff        <= '0;
         tc_ff        <= '0;
         err_ff       <= irc_lp_pkg::ST_OK;
         trail_ff     <= 1'b0;
         cmode_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pc_ff        <= pc_in;
         cc_ff        <= cc_in;
         tc_ff        <= tc_in;
         err_ff       <= err_in;
         trail_ff     <= trail_in;
         cmode_ff     <= cmode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (step) begin
         out_byte_ff  <= o_byte;
         kind_ff      <= o_kind;
         pidx_ff      <= o_pidx;
         cidx_ff      <= o_cidx;
         end_ff       <= o_end;
         ckind_ff     <= o_ckind;
         cval_ff      <= o_cval;
         pcnt_ff      <= o_pcnt;
         ccnt_ff      <= o_ccnt;
         trail_out_ff <= o_trail;
         status_ff    <= o_status;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_param_index   = pidx_ff;
   assign rsp_ctcp_index    = cidx_ff;
   assign rsp_line_end      = end_ff;
   assign rsp_command_kind  = ckind_ff;
   assign rsp_command_value = cval_ff;
   assign rsp_param_count   = pcnt_ff;
   assign rsp_ctcp_count    = ccnt_ff;
   assign rsp_has_trailing  = trail_out_ff;
   assign rsp_status        = status_ff;

   // checks
   a_stall_needs_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld)
      else $error("input stalled with an empty input register");

   a_line_restart: assert property (@(posedge clock) disable iff (reset)
      (step && term) |=> ((phase_ff == irc_lp_pkg::PH_START) && (pc_ff == '0) &&
                          (cc_ff == '0) && (tc_ff == '0)))
      else $error("line state not cleared after a terminator");

   a_ctcp_in_range: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == irc_lp_pkg::PH_TAG) || (phase_ff == irc_lp_pkg::PH_ARGS)) |->
         (cc_ff < CC_W'(CTCP_MAX)))
      else $error("open CTCP item beyond the limit");

   a_text_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == irc_lp_pkg::PH_TEXT) |-> (tc_ff < TC_W'(TEXT_MAX)))
      else $error("text counter at the limit while text is still kept");

endmodule
